// ===== rtl/core/llp_pkg.sv =====
// Package of the LL(1) parser core: sizes, item types, codes and states.
package llp_pkg;

  // Default sizes of the parser.
  localparam int NONTERMINALS_DEF   = 64;
  localparam int TOKENS_DEF         = 64;
  localparam int PRODUCTIONS_DEF    = 128;
  localparam int MAX_RHS_DEF        = 8;
  localparam int STACK_DEPTH_DEF    = 64;
  localparam int MAX_EXPANSIONS_DEF = 32;

  // Action codes of an input item.
  typedef enum logic [1:0] {
    ACT_CELL    = 2'd0,
    ACT_SYMBOL  = 2'd1,
    ACT_RESTART = 2'd2,
    ACT_TOKEN   = 2'd3
  } action_t;

  // Event codes of a result item.
  typedef enum logic [3:0] {
    EV_LOADED    = 4'd0,
    EV_RESTARTED = 4'd1,
    EV_EXPANDED  = 4'd2,
    EV_MATCHED   = 4'd3,
    EV_ACCEPTED  = 4'd4,
    EV_UNEXPECT  = 4'd5,
    EV_MISMATCH  = 4'd6,
    EV_MISSING   = 4'd7,
    EV_OVERFLOW  = 4'd8,
    EV_IGNORED   = 4'd9,
    EV_LIMIT     = 4'd10
  } event_t;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_START = 1'b0,
    CFG_EOF   = 1'b1
  } cfg_index_t;

  typedef struct packed {
    action_t    action;
    logic [5:0] nonterminal;
    logic [5:0] token;
    logic [6:0] production;
    logic       entry_valid;
    logic [2:0] position;
    logic       symbol_is_terminal;
    logic [5:0] symbol_code;
    logic [3:0] rhs_length;
  } in_item_t;

  typedef struct packed {
    event_t     event_res;
    logic [6:0] applied_production;
    logic       top_is_terminal;
    logic [5:0] top_code;
    logic       last;
  } out_item_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH,
    ST_TOP,
    ST_CELL,
    ST_LEN,
    ST_SYM_RD,
    ST_SYM_WR
  } state_t;

endpackage

// ===== rtl/core/llp_if.sv =====
// Channel interfaces of the LL(1) parser core: input, result and configuration.
interface llp_in_if import llp_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t item;
  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface llp_out_if import llp_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t item;
  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface llp_cfg_if import llp_pkg::*; ();
  logic       valid;
  logic       ready;
  cfg_index_t index;
  logic [5:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/ll1_table_driven_parser_core.sv =====
// Top level of the LL(1) table-driven predictive parser core.
//
// Input items arrive on in_ch: table cell writes, production symbol writes,
// restarts and tokens. Each item yields one or more result items on out_ch,
// the final one flagged by last. Registers are written on cfg_ch, which is
// always ready; write them only while the core is idle.
// Loads, restarts and halted tokens yield a result item in the cycle after they
// are taken. A token reads the stack top; for each expansion it reads the table
// cell and the right-hand-side length, reads and pushes each symbol in turn,
// and places the expansion item before the new top is read; a plain match
// reads the top and places the match item.
// After reset the core sweeps all NONTERMINALS*TOKENS cells (4096 by default)
// of the parse table clear, one cell a cycle, with in_ch not ready. The
// parser then stays halted until the first restart.
// A result item waits in an output register; when the receiver stalls, the
// sequencer holds wherever it must emit, and in_ch stays not ready while a
// result cannot be placed.
module ll1_table_driven_parser_core import llp_pkg::*; #(
  parameter int NONTERMINALS   = NONTERMINALS_DEF,
  parameter int TOKENS         = TOKENS_DEF,
  parameter int PRODUCTIONS    = PRODUCTIONS_DEF,
  parameter int MAX_RHS        = MAX_RHS_DEF,
  parameter int STACK_DEPTH    = STACK_DEPTH_DEF,
  parameter int MAX_EXPANSIONS = MAX_EXPANSIONS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  llp_in_if.sink     in_ch,
  llp_out_if.source  out_ch,
  llp_cfg_if.sink    cfg_ch
);

  localparam int TBL_DEPTH = NONTERMINALS * TOKENS;
  localparam int TBL_AW    = $clog2(TBL_DEPTH);
  localparam int SYM_DEPTH = PRODUCTIONS * MAX_RHS;
  localparam int SYM_AW    = $clog2(SYM_DEPTH);
  localparam int PR_AW     = $clog2(PRODUCTIONS);
  localparam int LEN_W     = $clog2(MAX_RHS + 1);
  localparam int SP_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W     = $clog2(STACK_DEPTH + 1);
  localparam int DONE_W    = $clog2(MAX_EXPANSIONS + 1);

  // Memories.
  logic [7:0]       tbl_mem [TBL_DEPTH];
  logic [6:0]       sym_mem [SYM_DEPTH];
  logic [LEN_W-1:0] len_mem [PRODUCTIONS];
  logic [6:0]       stk_mem [STACK_DEPTH];

  logic [7:0]       tbl_rd_r;
  logic [6:0]       sym_rd_r;
  logic [LEN_W-1:0] len_rd_r;
  logic [6:0]       stk_rd_r;

  // Control registers.
  state_t            state_r, state_nxt;
  logic [TBL_AW-1:0] clr_r, clr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              halted_r, halted_nxt;
  logic [DONE_W-1:0] done_r, done_nxt;
  logic [LEN_W-1:0]  sym_i_r, sym_i_nxt;
  logic [5:0]        tok_r, tok_nxt;
  logic [6:0]        prod_r, prod_nxt;
  logic              prod_oob_r, prod_oob_nxt;
  logic              cell_oob_r, cell_oob_nxt;
  logic [5:0]        start_r, eof_r;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_item_r;

  // Memory access controls.
  logic              tbl_we, tbl_re;
  logic [TBL_AW-1:0] tbl_waddr, tbl_raddr;
  logic [7:0]        tbl_wdata;
  logic              sym_we, sym_re;
  logic [SYM_AW-1:0] sym_waddr, sym_raddr;
  logic              len_we, len_re;
  logic [PR_AW-1:0]  len_waddr, len_raddr;
  logic [LEN_W-1:0]  len_wdata;
  logic              stk_we, stk_re;
  logic [SP_W-1:0]   stk_waddr, stk_raddr;
  logic [6:0]        stk_wdata;

  logic      emit;
  out_item_t emit_item;

  // Shared decode of the current step.
  in_item_t         in_item;
  logic             can_emit, in_fire;
  logic             top_term, tok_eof, tok_match, cell_hit, exp_limit, ovf;
  logic [5:0]       top_code;
  logic [6:0]       cell_prod;
  logic [LEN_W-1:0] len_eff, rlen_clamp;
  logic [CNT_W-1:0] count_dec;
  logic             cell_ok, sym_ok, lookup_ok;

  assign in_item    = in_ch.item;
  assign can_emit   = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE) && can_emit;
  assign in_fire    = in_ch.valid && in_ch.ready;
  assign top_term   = stk_rd_r[6];
  assign top_code   = stk_rd_r[5:0];
  assign tok_eof    = (tok_r == eof_r);
  assign tok_match  = (top_code == tok_r);
  assign cell_hit   = !cell_oob_r && tbl_rd_r[7];
  assign cell_prod  = tbl_rd_r[6:0];
  assign exp_limit  = (int'(done_r) >= MAX_EXPANSIONS);
  assign len_eff    = prod_oob_r ? '0 : len_rd_r;
  assign ovf        = (int'(count_r) - 1 + int'(len_eff)) > STACK_DEPTH;
  assign count_dec  = count_r - CNT_W'(1);
  assign cell_ok    = (int'(in_item.nonterminal) < NONTERMINALS) &&
                      (int'(in_item.token) < TOKENS) &&
                      (int'(in_item.production) < PRODUCTIONS);
  assign sym_ok     = (int'(in_item.production) < PRODUCTIONS) &&
                      (int'(in_item.position) < MAX_RHS);
  assign lookup_ok  = (int'(top_code) < NONTERMINALS) && (int'(tok_r) < TOKENS);
  assign rlen_clamp = (int'(in_item.rhs_length) > MAX_RHS) ? LEN_W'(MAX_RHS)
                                                           : LEN_W'(in_item.rhs_length);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (int'(clr_r) == TBL_DEPTH - 1) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire && in_item.action == ACT_TOKEN && !halted_r) state_nxt = ST_FETCH;
      end
      ST_FETCH: begin
        if (count_r != '0) state_nxt = ST_TOP;
        else if (can_emit) state_nxt = ST_IDLE;
      end
      ST_TOP: begin
        if (!top_term) state_nxt = ST_CELL;
        else if (can_emit) state_nxt = ST_IDLE;
      end
      ST_CELL: begin
        if (cell_hit && !exp_limit) state_nxt = ST_LEN;
        else if (can_emit) state_nxt = ST_IDLE;
      end
      ST_LEN: begin
        if (!ovf) state_nxt = ST_SYM_RD;
        else if (can_emit) state_nxt = ST_IDLE;
      end
      ST_SYM_RD: begin
        if (sym_i_r != '0) state_nxt = ST_SYM_WR;
        else if (can_emit) state_nxt = ST_FETCH;
      end
      ST_SYM_WR: state_nxt = ST_SYM_RD;
      default:   state_nxt = ST_CLEAR;
    endcase
  end

  // Datapath controls and result items.
  always_comb begin
    clr_nxt      = clr_r;
    count_nxt    = count_r;
    halted_nxt   = halted_r;
    done_nxt     = done_r;
    sym_i_nxt    = sym_i_r;
    tok_nxt      = tok_r;
    prod_nxt     = prod_r;
    prod_oob_nxt = prod_oob_r;
    cell_oob_nxt = cell_oob_r;
    tbl_we       = 1'b0;
    tbl_re       = 1'b0;
    tbl_waddr    = TBL_AW'(int'(in_item.nonterminal) * TOKENS + int'(in_item.token));
    tbl_raddr    = TBL_AW'(int'(top_code) * TOKENS + int'(tok_r));
    tbl_wdata    = in_item.entry_valid ? {1'b1, in_item.production} : 8'd0;
    sym_we       = 1'b0;
    sym_re       = 1'b0;
    sym_waddr    = SYM_AW'(int'(in_item.production) * MAX_RHS + int'(in_item.position));
    sym_raddr    = SYM_AW'(int'(prod_r) * MAX_RHS + int'(sym_i_r) - 1);
    len_we       = 1'b0;
    len_re       = 1'b0;
    len_waddr    = PR_AW'(in_item.production);
    len_raddr    = PR_AW'(cell_prod);
    len_wdata    = rlen_clamp;
    stk_we       = 1'b0;
    stk_re       = 1'b0;
    stk_waddr    = count_r[SP_W-1:0];
    stk_raddr    = count_dec[SP_W-1:0];
    stk_wdata    = sym_rd_r;
    emit         = 1'b0;
    emit_item    = '{event_res: EV_LOADED, applied_production: 7'd0,
                     top_is_terminal: 1'b0, top_code: 6'd0, last: 1'b1};
    unique case (state_r)
      // Sweep the parse table clear after reset.
      ST_CLEAR: begin
        tbl_we    = 1'b1;
        tbl_waddr = clr_r;
        tbl_wdata = 8'd0;
        clr_nxt   = clr_r + TBL_AW'(1);
      end
      // Take a new item; loads, restarts and halted tokens finish here.
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_item.action)
            ACT_CELL: begin
              emit = 1'b1;
              if (cell_ok) tbl_we = 1'b1;
              else emit_item.event_res = EV_IGNORED;
            end
            ACT_SYMBOL: begin
              emit = 1'b1;
              if (sym_ok) begin
                sym_we = 1'b1;
                len_we = 1'b1;
              end else begin
                emit_item.event_res = EV_IGNORED;
              end
            end
            ACT_RESTART: begin
              emit                = 1'b1;
              emit_item.event_res = EV_RESTARTED;
              emit_item.top_code  = start_r;
              stk_we              = 1'b1;
              stk_waddr           = '0;
              stk_wdata           = {1'b0, start_r};
              count_nxt           = CNT_W'(1);
              halted_nxt          = 1'b0;
            end
            ACT_TOKEN: begin
              tok_nxt  = in_item.token;
              done_nxt = '0;
              if (halted_r) begin
                emit                = 1'b1;
                emit_item.event_res = EV_IGNORED;
              end
            end
            default: ;
          endcase
        end
      end
      // Read the stack top, or finish on an empty stack.
      ST_FETCH: begin
        if (count_r != '0) begin
          stk_re = 1'b1;
        end else if (can_emit) begin
          emit                = 1'b1;
          emit_item.event_res = tok_eof ? EV_ACCEPTED : EV_UNEXPECT;
          halted_nxt          = 1'b1;
        end
      end
      // Terminal on top: match or error; nonterminal: look up the table.
      ST_TOP: begin
        if (!top_term) begin
          tbl_re       = lookup_ok;
          cell_oob_nxt = !lookup_ok;
        end else if (can_emit) begin
          emit                      = 1'b1;
          emit_item.top_is_terminal = 1'b1;
          emit_item.top_code        = top_code;
          if (tok_match) begin
            emit_item.event_res = EV_MATCHED;
            count_nxt           = count_dec;
          end else begin
            emit_item.event_res = tok_eof ? EV_MISSING : EV_MISMATCH;
            halted_nxt          = 1'b1;
          end
        end
      end
      // Check the table cell and the expansion budget.
      ST_CELL: begin
        if (cell_hit && !exp_limit) begin
          len_re       = (int'(cell_prod) < PRODUCTIONS);
          prod_nxt     = cell_prod;
          prod_oob_nxt = !(int'(cell_prod) < PRODUCTIONS);
        end else if (can_emit) begin
          emit               = 1'b1;
          emit_item.top_code = top_code;
          halted_nxt         = 1'b1;
          if (!cell_hit) emit_item.event_res = tok_eof ? EV_MISSING : EV_UNEXPECT;
          else           emit_item.event_res = EV_LIMIT;
        end
      end
      // Check the stack room and pop the nonterminal.
      ST_LEN: begin
        if (!ovf) begin
          count_nxt = count_dec;
          sym_i_nxt = len_eff;
        end else if (can_emit) begin
          emit                         = 1'b1;
          emit_item.event_res          = EV_OVERFLOW;
          emit_item.applied_production = prod_r;
          emit_item.top_code           = top_code;
          halted_nxt                   = 1'b1;
        end
      end
      // Fetch the next right-hand-side symbol, rightmost first, or place the expansion item when none is left.
      ST_SYM_RD: begin
        if (sym_i_r != '0) begin
          sym_re = 1'b1;
        end else if (can_emit) begin
          emit                         = 1'b1;
          emit_item.event_res          = EV_EXPANDED;
          emit_item.applied_production = prod_r;
          emit_item.top_code           = top_code;
          emit_item.last               = 1'b0;
          done_nxt                     = done_r + DONE_W'(1);
        end
      end
      // Push the fetched symbol.
      ST_SYM_WR: begin
        stk_we    = 1'b1;
        count_nxt = count_r + CNT_W'(1);
        sym_i_nxt = sym_i_r - LEN_W'(1);
      end
      default: ;
    endcase
  end

  assign out_valid_nxt = emit || (out_valid_r && !out_ch.ready);
  assign out_ch.valid  = out_valid_r;
  assign out_ch.item   = out_item_r;
  assign cfg_ch.ready  = 1'b1;

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      count_r     <= '0;
      halted_r    <= 1'b1;
      done_r      <= '0;
      sym_i_r     <= '0;
      out_valid_r <= 1'b0;
      start_r     <= '0;
      eof_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      count_r     <= count_nxt;
      halted_r    <= halted_nxt;
      done_r      <= done_nxt;
      sym_i_r     <= sym_i_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          CFG_START: start_r <= cfg_ch.data;
          CFG_EOF:   eof_r   <= cfg_ch.data;
          default: ;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    tok_r      <= tok_nxt;
    prod_r     <= prod_nxt;
    prod_oob_r <= prod_oob_nxt;
    cell_oob_r <= cell_oob_nxt;
    if (emit) out_item_r <= emit_item;
  end

  // Parse table memory.
  always_ff @(posedge clk) begin
    if (tbl_we) tbl_mem[tbl_waddr] <= tbl_wdata;
    if (tbl_re) tbl_rd_r <= tbl_mem[tbl_raddr];
  end

  // Right-hand-side symbol memory.
  always_ff @(posedge clk) begin
    if (sym_we) sym_mem[sym_waddr] <= {in_item.symbol_is_terminal, in_item.symbol_code};
    if (sym_re) sym_rd_r <= sym_mem[sym_raddr];
  end

  // Right-hand-side length memory; an out-of-range production reads as zero.
  always_ff @(posedge clk) begin
    if (len_we) len_mem[len_waddr] <= len_wdata;
    if (len_re) len_rd_r <= len_mem[len_raddr];
  end

  // Symbol stack memory.
  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
    if (stk_re) stk_rd_r <= stk_mem[stk_raddr];
  end

endmodule

// ===== rtl/core/llp_checker.sv =====
// Port checker of the LL(1) parser core and its bind to the top level.
module llp_checker import llp_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_item
);

  // A stalled result item holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result item changed while stalled");

  // Only expansions and overflows carry a production.
  a_prod_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.event_res != EV_EXPANDED && out_item.event_res != EV_OVERFLOW
    |-> out_item.applied_production == 7'd0)
    else $error("production on an event that has none");

  // An expansion is never the final result of a token.
  a_exp_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.event_res == EV_EXPANDED |-> !out_item.last)
    else $error("expansion flagged as last");

  // No new item is taken while a token is still being worked on.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.last |-> !in_ready)
    else $error("input ready in the middle of a token");

endmodule

bind ll1_table_driven_parser_core llp_checker u_llp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_item  (out_ch.item)
);
